// ===== src/free_extent_gap_finder_defines.svh =====
// assertion macros shared by the gap finder checker
// no dependencies; included by files that assert
`ifndef FREE_EXTENT_GAP_FINDER_DEFINES_SVH
`define FREE_EXTENT_GAP_FINDER_DEFINES_SVH

// clocked check, off while reset is held
`define FEGF_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: check failed");

// clocked check that also runs through reset
`define FEGF_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");

`endif

// ===== src/fegf_pkg.sv =====
// shared types and constants of the free extent gap finder
// no dependencies
package fegf_pkg;

    localparam int SECTOR_BITS_DEFAULT = 48;
    localparam int THRESH_BITS         = 21;
    localparam int SHIFT_BITS          = 5;
    localparam int CFG_IDX_BITS        = 2;

    localparam logic [THRESH_BITS-1:0] MIB_BYTES         = THRESH_BITS'(1) << 20;
    localparam logic [SHIFT_BITS-1:0]  SECTOR_SHIFT_RESET = SHIFT_BITS'(9);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_REGION_START  = 2'd0,
        CFG_REGION_END    = 2'd1,
        CFG_SECTOR_SHIFT  = 2'd2,
        CFG_NESTED_REGION = 2'd3
    } cfg_index_t;

    localparam logic KIND_EXTENT = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef struct packed {
        logic emit;
        logic seen_next;
    } fegf_status_t;

endpackage

// ===== src/free_extent_gap_finder.sv =====
// top level of the free extent gap finder: handshakes, state and result register
// depends on fegf_pkg, fegf_cfg_regs and fegf_eval
//
// Takes the sorted allocated extents of a sector region, one item each, and
// then an end-of-list item, and returns the unallocated gaps: at most one gap
// per item. One item is accepted every cycle unless an item with a gap is held
// in the input register while the result register holds a result not yet taken.
// An accepted item goes through an input register, the combinational evaluator
// that compares it against the saved last extent end, and the result register.
// The saved state is updated as an item leaves the input register, so the next
// item sees it at once. An item that produces no gap never waits on the result
// side. Configuration writes are accepted every cycle and must be made while no item is in flight.
module free_extent_gap_finder import fegf_pkg::*; #(
    parameter int SECTOR_BITS = SECTOR_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SECTOR_BITS-1:0]  cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic [SECTOR_BITS-1:0]  s_part_start,
    input  logic [SECTOR_BITS-1:0]  s_part_end,
    input  logic                    s_is_logical,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SECTOR_BITS-1:0]  m_gap_start,
    output logic [SECTOR_BITS-1:0]  m_gap_end,
    output logic                    m_in_extended
);

    logic [SECTOR_BITS-1:0] region_start;
    logic [SECTOR_BITS-1:0] region_end;
    logic [THRESH_BITS-1:0] threshold;
    logic                   nested_region;

    logic                   in_valid_reg;
    logic                   in_kind_reg;
    logic [SECTOR_BITS-1:0] in_start_reg;
    logic [SECTOR_BITS-1:0] in_end_reg;
    logic                   in_logical_reg;

    logic                   seen_reg;
    logic [SECTOR_BITS-1:0] last_end_reg;

    logic                   out_valid_reg;
    logic [SECTOR_BITS-1:0] out_start_reg;
    logic [SECTOR_BITS-1:0] out_end_reg;
    logic                   out_ext_reg;

    fegf_status_t           status;
    logic [SECTOR_BITS-1:0] gap_start;
    logic [SECTOR_BITS-1:0] gap_end;
    logic [SECTOR_BITS-1:0] last_end_next;
    logic                   out_free;
    logic                   advance;
    logic                   load_out;

    fegf_cfg_regs #(.SECTOR_BITS(SECTOR_BITS)) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .region_start  (region_start),
        .region_end    (region_end),
        .threshold     (threshold),
        .nested_region (nested_region)
    );

    fegf_eval #(.SECTOR_BITS(SECTOR_BITS)) u_eval (
        .kind          (in_kind_reg),
        .part_start    (in_start_reg),
        .part_end      (in_end_reg),
        .is_logical    (in_logical_reg),
        .seen_any      (seen_reg),
        .last_end      (last_end_reg),
        .region_start  (region_start),
        .region_end    (region_end),
        .threshold     (threshold),
        .status        (status),
        .gap_start     (gap_start),
        .gap_end       (gap_end),
        .last_end_next (last_end_next)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!status.emit || out_free);
    assign load_out = advance && status.emit;
    assign s_ready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_kind_reg    <= s_kind;
            in_start_reg   <= s_part_start;
            in_end_reg     <= s_part_end;
            in_logical_reg <= s_is_logical;
        end
    end

    // extent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= 1'b0;
            last_end_reg <= '0;
        end else if (advance) begin
            seen_reg     <= status.seen_next;
            last_end_reg <= last_end_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= load_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_start_reg <= gap_start;
            out_end_reg   <= gap_end;
            out_ext_reg   <= nested_region;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_gap_start   = out_start_reg;
    assign m_gap_end     = out_end_reg;
    assign m_in_extended = out_ext_reg;

endmodule

// ===== src/fegf_cfg_regs.sv =====
// configuration registers and threshold derivation
// depends on fegf_pkg
module fegf_cfg_regs import fegf_pkg::*; #(
    parameter int SECTOR_BITS = SECTOR_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SECTOR_BITS-1:0]  cfg_data,
    output logic [SECTOR_BITS-1:0]  region_start,
    output logic [SECTOR_BITS-1:0]  region_end,
    output logic [THRESH_BITS-1:0]  threshold,
    output logic                    nested_region
);

    logic [SECTOR_BITS-1:0] region_start_reg;
    logic [SECTOR_BITS-1:0] region_end_reg;
    logic [SHIFT_BITS-1:0]  sector_shift_reg;
    logic                   nested_region_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_start_reg  <= '0;
            region_end_reg    <= '0;
            sector_shift_reg  <= SECTOR_SHIFT_RESET;
            nested_region_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REGION_START:  region_start_reg  <= cfg_data;
                CFG_REGION_END:    region_end_reg    <= cfg_data;
                CFG_SECTOR_SHIFT:  sector_shift_reg  <= cfg_data[SHIFT_BITS-1:0];
                CFG_NESTED_REGION: nested_region_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // one mebibyte counted in sectors
    assign threshold     = MIB_BYTES >> sector_shift_reg;
    assign region_start  = region_start_reg;
    assign region_end    = region_end_reg;
    assign nested_region = nested_region_reg;

endmodule

// ===== src/fegf_eval.sv =====
// gap decision logic for one item against the saved extent state
// depends on fegf_pkg
module fegf_eval import fegf_pkg::*; #(
    parameter int SECTOR_BITS = SECTOR_BITS_DEFAULT
) (
    input  logic                   kind,
    input  logic [SECTOR_BITS-1:0] part_start,
    input  logic [SECTOR_BITS-1:0] part_end,
    input  logic                   is_logical,
    input  logic                   seen_any,
    input  logic [SECTOR_BITS-1:0] last_end,
    input  logic [SECTOR_BITS-1:0] region_start,
    input  logic [SECTOR_BITS-1:0] region_end,
    input  logic [THRESH_BITS-1:0] threshold,
    output fegf_status_t           status,
    output logic [SECTOR_BITS-1:0] gap_start,
    output logic [SECTOR_BITS-1:0] gap_end,
    output logic [SECTOR_BITS-1:0] last_end_next
);

    logic [SECTOR_BITS-1:0] thr_wide;
    logic [SECTOR_BITS-1:0] head_dist;
    logic [SECTOR_BITS-1:0] mid_dist;
    logic [SECTOR_BITS-1:0] tail_dist;
    logic [SECTOR_BITS-1:0] last_next;
    logic [SECTOR_BITS-1:0] part_prev;

    assign thr_wide  = {{(SECTOR_BITS-THRESH_BITS){1'b0}}, threshold};
    assign head_dist = part_start - region_start;
    assign mid_dist  = part_start - last_end - SECTOR_BITS'(1);
    assign tail_dist = region_end - last_end;
    assign last_next = last_end + SECTOR_BITS'(1);
    assign part_prev = part_start - SECTOR_BITS'(1);

    always_comb begin
        status.emit      = 1'b0;
        status.seen_next = 1'b0;
        gap_start        = last_next;
        gap_end          = part_prev;
        last_end_next    = '0;
        if (kind == KIND_END) begin
            gap_end = region_end;
            if (!seen_any) begin
                status.emit = 1'b1;
                gap_start   = region_start;
            end else if (region_end >= last_end && tail_dist >= thr_wide) begin
                status.emit = 1'b1;
            end
        end else begin
            status.seen_next = 1'b1;
            last_end_next    = part_end;
            if (!seen_any) begin
                gap_start = region_start;
                if (part_start > region_start && head_dist > thr_wide) begin
                    status.emit = 1'b1;
                end
            end else if (part_start > last_end) begin
                if (mid_dist > thr_wide || (mid_dist == thr_wide && !is_logical)) begin
                    status.emit = 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/fegf_checker.sv =====
// port-level checks for the free extent gap finder, bound to the top level
// depends on fegf_pkg and free_extent_gap_finder_defines.svh
`include "free_extent_gap_finder_defines.svh"

module fegf_checker import fegf_pkg::*; #(
    parameter int SECTOR_BITS = SECTOR_BITS_DEFAULT
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SECTOR_BITS-1:0] m_gap_start,
    input logic [SECTOR_BITS-1:0] m_gap_end,
    input logic                   m_in_extended
);

    // a stalled result holds
    `FEGF_ASSERT_CLK(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_gap_start) && $stable(m_gap_end)
        && $stable(m_in_extended))

    // reset leaves no result and an open input
    `FEGF_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready)

    // with the result side empty the input never stalls
    `FEGF_ASSERT_CLK(a_no_false_stall, aclk, aresetn, !m_valid |-> s_ready)

endmodule

bind free_extent_gap_finder fegf_checker #(.SECTOR_BITS(SECTOR_BITS)) u_fegf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_gap_start   (m_gap_start),
    .m_gap_end     (m_gap_end),
    .m_in_extended (m_in_extended)
);

// ===== test/tb_free_extent_gap_finder.sv =====
// self-checking testbench for free_extent_gap_finder: sorted extent lists, noise items
// and register settings go in, and each gap that comes out is compared with a predicted one
// depends on fegf_pkg and the free_extent_gap_finder rtl
module tb_free_extent_gap_finder;
    import fegf_pkg::*;

    localparam int SB             = SECTOR_BITS_DEFAULT;
    localparam int STALL_PCT      = 38;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef logic [SB-1:0] sector_t;

    typedef struct packed {
        sector_t gap_start;
        sector_t gap_end;
        logic    in_extended;
    } gap_t;

    class gap_scoreboard;
        sector_t               region_start;
        sector_t               region_end;
        logic [SHIFT_BITS-1:0] sector_shift;
        logic                  nested_region;
        logic                  seen_any;
        sector_t               last_end;
        gap_t                  expected_gaps[$];
        int                    errors;

        function new();
            region_start  = '0;
            region_end    = '0;
            sector_shift  = SECTOR_SHIFT_RESET;
            nested_region = 1'b0;
            seen_any      = 1'b0;
            last_end      = '0;
            errors        = 0;
        endfunction

        function longint unsigned threshold();
            return (64'd1 << 20) >> sector_shift;
        endfunction

        function void write_reg(cfg_index_t idx, sector_t data);
            case (idx)
                CFG_REGION_START:  region_start  = data;
                CFG_REGION_END:    region_end    = data;
                CFG_SECTOR_SHIFT:  sector_shift  = data[SHIFT_BITS-1:0];
                CFG_NESTED_REGION: nested_region = data[0];
                default: ;
            endcase
        endfunction

        function void add_gap(sector_t first, sector_t last);
            gap_t g;
            g.gap_start   = first;
            g.gap_end     = last;
            g.in_extended = nested_region;
            expected_gaps = {expected_gaps, g};
        endfunction

        // predicts the gap, if any, caused by one accepted item
        function void note_item(logic kind, sector_t ps, sector_t pe, logic logical);
            longint unsigned t;
            sector_t         gap_len;
            t = threshold();
            if (kind == KIND_END) begin
                if (!seen_any) begin
                    add_gap(region_start, region_end);
                end else if (region_end >= last_end) begin
                    gap_len = region_end - last_end;
                    if (64'(gap_len) >= t) add_gap(last_end + 1'b1, region_end);
                end
                seen_any = 1'b0;
                last_end = '0;
            end else begin
                if (!seen_any) begin
                    if (ps > region_start) begin
                        gap_len = ps - region_start;
                        if (64'(gap_len) > t) add_gap(region_start, ps - 1'b1);
                    end
                end else if (ps > last_end) begin
                    gap_len = ps - last_end - 1'b1;
                    if (64'(gap_len) > t || (64'(gap_len) == t && !logical))
                        add_gap(last_end + 1'b1, ps - 1'b1);
                end
                seen_any = 1'b1;
                last_end = pe;
            end
        endfunction

        function void check_gap(sector_t first, sector_t last, logic ext);
            gap_t want;
            if (expected_gaps.size() == 0) begin
                errors++;
                $display("%0t: unexpected gap, expected none, actual start %h end %h ext %b",
                         $time, first, last, ext);
                return;
            end
            want = expected_gaps.pop_front();
            if (first !== want.gap_start) begin
                errors++;
                $display("%0t: gap_start expected %h actual %h", $time, want.gap_start, first);
            end
            if (last !== want.gap_end) begin
                errors++;
                $display("%0t: gap_end expected %h actual %h", $time, want.gap_end, last);
            end
            if (ext !== want.in_extended) begin
                errors++;
                $display("%0t: in_extended expected %b actual %b", $time, want.in_extended, ext);
            end
        endfunction

        function int pending();
            return expected_gaps.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    sector_t    cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic       s_kind;
    sector_t    s_part_start;
    sector_t    s_part_end;
    logic       s_is_logical;
    logic       m_valid;
    logic       m_ready;
    sector_t    m_gap_start;
    sector_t    m_gap_end;
    logic       m_in_extended;

    gap_scoreboard         gaps = new();
    int                    items_sent = 0;
    int                    idle_cycles = 0;
    logic                  steady = 1'b0;
    sector_t               cur_rs = '0;
    sector_t               cur_re = '0;
    longint unsigned       cur_t = 64'd2048;

    free_extent_gap_finder #(
        .SECTOR_BITS(SB)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_part_start (s_part_start),
        .s_part_end   (s_part_end),
        .s_is_logical (s_is_logical),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gap_start  (m_gap_start),
        .m_gap_end    (m_gap_end),
        .m_in_extended(m_in_extended)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result sink with random stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= aresetn && (steady || $urandom_range(0, 99) >= STALL_PCT);
        end
    end

    // monitor: results checked before the new item is noted, plus the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) gaps.check_gap(m_gap_start, m_gap_end, m_in_extended);
            if (cfg_valid && cfg_ready) gaps.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                gaps.note_item(s_kind, s_part_start, s_part_end, s_is_logical);
                items_sent++;
            end
            if ((m_valid && m_ready) || (cfg_valid && cfg_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: timeout, %0d gaps outstanding", $time, gaps.pending());
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    function automatic sector_t rand_sector();
        return sector_t'({$urandom, $urandom});
    endfunction

    // distances around the threshold, with some small and some far ones
    function automatic longint unsigned pick_distance(longint unsigned t);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return (t > 0) ? t - 1 : 0;
            2, 3:    return t;
            4:       return t + 1;
            5:       return $urandom_range(0, int'(3 * t + 8));
            6:       return $urandom_range(0, 255);
            default: return {32'd0, $urandom};
        endcase
    endfunction

    task automatic push_item(logic kind, sector_t ps, sector_t pe, logic logical);
        @(negedge aclk);
        if (!steady && $urandom_range(0, 99) < STALL_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_part_start <= ps;
        s_part_end   <= pe;
        s_is_logical <= logical;
        do @(posedge aclk); while (!s_ready);
    endtask

    // holds the sender until every predicted gap has come out
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (gaps.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, sector_t data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(sector_t rs, sector_t re, logic [SHIFT_BITS-1:0] shift,
                             logic nested);
        sector_t junk;
        junk = rand_sector();
        drain();
        write_reg(CFG_REGION_START, rs);
        write_reg(CFG_REGION_END, re);
        write_reg(CFG_SECTOR_SHIFT, {junk[SB-1:SHIFT_BITS], shift});
        write_reg(CFG_NESTED_REGION, {junk[SB-1:1], nested});
        cur_rs = rs;
        cur_re = re;
        cur_t  = (64'd1 << 20) >> shift;
    endtask

    // sorted extent list with random content, then end of list
    task automatic send_list(int n_ext);
        sector_t ps;
        sector_t pe;
        sector_t prev_end;
        prev_end = cur_rs;
        for (int i = 0; i < n_ext; i++) begin
            if (i == 0) ps = cur_rs + sector_t'(pick_distance(cur_t));
            else        ps = prev_end + 1'b1 + sector_t'(pick_distance(cur_t));
            if ($urandom_range(0, 3) == 0)      pe = ps;
            else if ($urandom_range(0, 9) == 0) pe = ps + sector_t'($urandom);
            else                                pe = ps + sector_t'($urandom_range(0, 4096));
            if (i == n_ext - 1 && $urandom_range(0, 99) < 60)
                pe = cur_re - sector_t'(pick_distance(cur_t));
            if ($urandom_range(0, 99) < 3) drain();
            push_item(KIND_EXTENT, ps, pe, 1'($urandom_range(0, 1)));
            prev_end = pe;
        end
        push_item(KIND_END, rand_sector(), rand_sector(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise(int n);
        for (int i = 0; i < n; i++) begin
            push_item(($urandom_range(0, 5) == 0) ? KIND_END : KIND_EXTENT,
                      rand_sector(), rand_sector(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_settings();
        sector_t                 rs;
        sector_t                 re;
        logic [SHIFT_BITS-1:0]   shift;
        case ($urandom_range(0, 3))
            0: begin
                rs = sector_t'($urandom_range(0, 1 << 20));
                re = rs + sector_t'($urandom_range(0, 1 << 24));
            end
            1: begin
                rs = rand_sector();
                re = rs + sector_t'($urandom);
            end
            2: begin
                rs = '1 - sector_t'($urandom_range(0, 1 << 22));
                re = rs + sector_t'($urandom_range(0, 1 << 23));
            end
            default: begin
                rs = rand_sector();
                re = rand_sector();
            end
        endcase
        case ($urandom_range(0, 5))
            0:       shift = 5'd9;
            1:       shift = 5'd16;
            2:       shift = 5'($urandom_range(9, 16));
            3:       shift = 5'd0;
            4:       shift = 5'($urandom_range(17, 31));
            default: shift = 5'($urandom_range(0, 31));
        endcase
        configure(rs, re, shift, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int base;
        int phase;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_REGION_START;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_kind       = KIND_EXTENT;
        s_part_start = '0;
        s_part_end   = '0;
        s_is_logical = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // threshold 2048: boundaries of the first, middle and tail tests
        configure(48'd1000, 48'd100000, 5'd9, 1'b1);
        push_item(KIND_END, '0, '0, 1'b0);
        push_item(KIND_EXTENT, 48'd3048, 48'd4000, 1'b0);
        push_item(KIND_EXTENT, 48'd6049, 48'd7000, 1'b1);
        push_item(KIND_EXTENT, 48'd9049, 48'd9999, 1'b0);
        push_item(KIND_EXTENT, 48'd12047, 48'd12100, 1'b0);
        push_item(KIND_EXTENT, 48'd14150, 48'd15000, 1'b1);
        push_item(KIND_EXTENT, 48'd14000, 48'd15500, 1'b0);
        push_item(KIND_EXTENT, 48'd100, 48'd97952, 1'b0);
        push_item(KIND_END, '1, '1, 1'b1);
        push_item(KIND_EXTENT, 48'd3049, 48'd98000, 1'b0);
        push_item(KIND_END, '0, '0, 1'b0);
        push_item(KIND_EXTENT, '0, '1, 1'b1);
        push_item(KIND_END, '0, '0, 1'b0);

        // zero threshold with a reversed region: the tail gap ends before it starts
        configure('1, '0, 5'd31, 1'b0);
        push_item(KIND_END, '0, '0, 1'b0);
        push_item(KIND_EXTENT, '0, '0, 1'b0);
        push_item(KIND_END, '0, '0, 1'b0);

        // largest threshold across the whole sector range
        configure('0, '1, 5'd0, 1'b1);
        push_item(KIND_EXTENT, '1, '1, 1'b0);
        push_item(KIND_END, '0, '0, 1'b0);
        push_item(KIND_EXTENT, 48'h10_0001, 48'h10_0001, 1'b1);
        push_item(KIND_EXTENT, 48'h20_0002, '1 - 48'h10_0000, 1'b0);
        push_item(KIND_END, '1, '0, 1'b0);

        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            random_settings();
            steady = (phase == 2);
            repeat (steady ? 20 : $urandom_range(2, 6)) begin
                if ($urandom_range(0, 99) < 85) send_list($urandom_range(0, 8));
                else                            send_noise($urandom_range(1, 6));
            end
            phase++;
        end
        steady = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (gaps.pending() != 0) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (gaps.errors == 0 && gaps.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
